[rtl/dcp_pkg.sv]
// Package for the distance constraint projection block.
// Widths, payload and sideband struct types shared by all rtl/ modules.
`default_nettype none

package dcp_pkg;

  localparam int COORD_W  = 32;
  localparam int MASS_W   = 32;
  localparam int REST_W   = 31;
  localparam int MAG_W    = COORD_W + 1;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int ROOT_W   = MAG_W;
  localparam int REM_W    = ROOT_W + 2;
  localparam int DEN_W    = MAG_W;
  localparam int QUO_W    = MAG_W;
  localparam int NUM_W    = DEN_W + QUO_W;
  localparam int PIPE_STG = MAG_W;
  localparam int EXT_W    = MAG_W + 2;

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam logic [0:0] REG_REST_LENGTH = 1'b0;
  localparam logic [REST_W-1:0] REST_RESET = REST_W'(6553600);

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic        [MASS_W-1:0]  first_mass;
    logic        [MASS_W-1:0]  second_mass;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_first_x;
    logic signed [COORD_W-1:0] new_first_y;
    logic signed [COORD_W-1:0] new_second_x;
    logic signed [COORD_W-1:0] new_second_y;
    logic                      degenerate;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] p1x;
    logic signed [COORD_W-1:0] p1y;
    logic signed [COORD_W-1:0] p2x;
    logic signed [COORD_W-1:0] p2y;
    logic        [MASS_W-1:0]  m1;
    logic        [MASS_W-1:0]  m2;
    logic        [MAG_W-1:0]   mag_x;
    logic        [MAG_W-1:0]   mag_y;
    logic                      neg_x;
    logic                      neg_y;
    logic                      eneg;
    logic                      degen;
  } side_t;

endpackage

`default_nettype wire

[rtl/dcp_sqrt.sv]
// Pipelined floor square root, one result bit per stage.
// Uses dcp_pkg widths; advances when en is high.
`default_nettype none

module dcp_sqrt
  import dcp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [SQ_W-1:0]   n,
  output logic      [ROOT_W-1:0] root
);

  logic [REM_W-1:0]  rem_r  [PIPE_STG-1];
  logic [SQ_W-1:0]   n_r    [PIPE_STG-1];
  logic [ROOT_W-1:0] root_r [PIPE_STG];

  for (genvar g = 0; g < PIPE_STG; g++) begin : g_stg
    logic [REM_W-1:0]  rem_in;
    logic [SQ_W-1:0]   n_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  acc;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              take;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign n_in    = n;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign n_in    = n_r[g-1];
      assign root_in = root_r[g-1];
    end

    assign acc   = {rem_in, n_in[SQ_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = acc - trial;
    assign take  = (acc >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[g] <= {root_in[ROOT_W-2:0], take};
      end
    end

    if (g < PIPE_STG - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= take ? diff[REM_W-1:0] : acc[REM_W-1:0];
          n_r[g]   <= {n_in[SQ_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_r[PIPE_STG-1];

endmodule

`default_nettype wire

[rtl/dcp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Numerator top half must be below the divisor. Uses dcp_pkg widths.
`default_nettype none

module dcp_div
  import dcp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r [PIPE_STG-1];
  logic [QUO_W-1:0] lo_r  [PIPE_STG-1];
  logic [DEN_W-1:0] den_r [PIPE_STG-1];
  logic [QUO_W-1:0] q_r   [PIPE_STG];

  for (genvar g = 0; g < PIPE_STG; g++) begin : g_stg
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] lo_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] q_in;
    logic [DEN_W:0]   acc;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (g == 0) begin : g_first
      assign rem_in = num[NUM_W-1 -: DEN_W];
      assign lo_in  = num[QUO_W-1:0];
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign lo_in  = lo_r[g-1];
      assign den_in = den_r[g-1];
      assign q_in   = q_r[g-1];
    end

    assign acc  = {rem_in, lo_in[QUO_W-1]};
    assign diff = acc - {1'b0, den_in};
    assign ge   = (acc >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[g] <= {q_in[QUO_W-2:0], ge};
      end
    end

    if (g < PIPE_STG - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= ge ? diff[DEN_W-1:0] : acc[DEN_W-1:0];
          lo_r[g]  <= {lo_in[QUO_W-2:0], 1'b0};
          den_r[g] <= den_in;
        end
      end
    end
  end

  assign quo = q_r[PIPE_STG-1];

endmodule

`default_nettype wire

[rtl/dcp_delay.sv]
// Valid and sideband delay line matching the sqrt/divider depth.
// Uses dcp_pkg side_t.
`default_nettype none

module dcp_delay
  import dcp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  vld_in,
  input  wire side_t side_in,
  output logic       vld_out,
  output side_t      side_out
);

  logic  vld_r  [PIPE_STG];
  side_t side_r [PIPE_STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_STG; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_in;
      for (int i = 1; i < PIPE_STG; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < PIPE_STG; i++) side_r[i] <= side_r[i-1];
    end
  end

  assign vld_out  = vld_r[PIPE_STG-1];
  assign side_out = side_r[PIPE_STG-1];

endmodule

`default_nettype wire

[rtl/distance_constraint_projection_top.sv]
// Top level of the distance constraint projection block.
// Depends on dcp_pkg, dcp_sqrt, dcp_div and dcp_delay.
`default_nettype none

// Projects two point masses onto the configured rest length, each point moving
// by the other's mass share. One transaction per cycle is accepted unless the
// output stalls; a stall freezes the whole pipeline. The bit-per-stage square
// root (33 stages) and two bit-per-stage divider chains (33 stages each) lie
// in series. Coincident points or zero total mass pass the positions unchanged
// with degenerate set. rest_length is at byte address 0; the user must change
// it only while the block is idle, which the block itself does not enforce.
module distance_constraint_projection_top
  import dcp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_t                   out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  function automatic logic signed [COORD_W-1:0] sat_move(
    input logic signed [COORD_W-1:0] p,
    input logic        [QUO_W-1:0]   mv,
    input logic                      negate
  );
    logic signed [EXT_W-1:0] mvs;
    logic signed [EXT_W-1:0] sum;
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    logic signed [COORD_W-1:0] res;
    mvs = $signed({2'b00, mv});
    sum = EXT_W'(p) + (negate ? -mvs : mvs);
    hi  = EXT_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo  = -hi - EXT_W'(1);
    if (sum > hi) res = hi[COORD_W-1:0];
    else if (sum < lo) res = lo[COORD_W-1:0];
    else res = sum[COORD_W-1:0];
    return res;
  endfunction

  logic              adv;
  logic [REST_W-1:0] rest_r;
  logic              cfg_wr;

  // config register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[CFG_AW-1:2] == REG_REST_LENGTH);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_REST_LENGTH)
                      ? CFG_DW'(rest_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= REST_RESET;
    end else if (cfg_wr) begin
      rest_r <= cfg_pwdata[REST_W-1:0];
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage a: differences
  logic                    a_vld_r;
  side_t                   a_side_r, a_side_nxt;
  logic signed [MAG_W-1:0] dx, dy;

  always_comb begin
    dx = MAG_W'(in_data.second_x) - MAG_W'(in_data.first_x);
    dy = MAG_W'(in_data.second_y) - MAG_W'(in_data.first_y);
    a_side_nxt.p1x   = in_data.first_x;
    a_side_nxt.p1y   = in_data.first_y;
    a_side_nxt.p2x   = in_data.second_x;
    a_side_nxt.p2y   = in_data.second_y;
    a_side_nxt.m1    = in_data.first_mass;
    a_side_nxt.m2    = in_data.second_mass;
    a_side_nxt.neg_x = dx[MAG_W-1];
    a_side_nxt.neg_y = dy[MAG_W-1];
    a_side_nxt.mag_x = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    a_side_nxt.mag_y = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    a_side_nxt.eneg  = 1'b0;
    a_side_nxt.degen = (in_data.first_mass == '0) && (in_data.second_mass == '0);
  end

  // stage b: squares; stage c: sum
  logic            b_vld_r, c_vld_r;
  side_t           b_side_r, c_side_r;
  logic [SQ_W-1:0] b_sqx_r, b_sqy_r, c_sq_r;

  // stage e: length error; stage f: products
  logic             d0_vld, e_vld_r, f_vld_r;
  side_t            d0_side, e_side_r, e_side_nxt, f_side_r;
  logic [ROOT_W-1:0] len;
  logic [MAG_W-1:0] e_len_r, e_ae_r, f_len_r;
  logic [MAG_W-1:0] ae_nxt;
  logic [NUM_W-1:0] f_numx_r, f_numy_r;

  // stage g: mass products
  logic             d1_vld, g_vld_r;
  side_t            d1_side, g_side_r;
  logic [QUO_W-1:0] tx, ty;
  logic [NUM_W-1:0] g_num_r [4];
  logic [DEN_W-1:0] g_msum_r;

  // output stage
  logic             d2_vld;
  side_t            d2_side;
  logic [QUO_W-1:0] mv [4];
  logic             out_valid_r;
  out_t             out_data_r, out_nxt;
  logic             tneg_x, tneg_y;

  always_comb begin
    e_side_nxt = d0_side;
    e_side_nxt.eneg  = (len < ROOT_W'(rest_r));
    e_side_nxt.degen = d0_side.degen || (len == '0);
    ae_nxt = e_side_nxt.eneg ? MAG_W'(rest_r) - len : len - MAG_W'(rest_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      e_vld_r     <= 1'b0;
      f_vld_r     <= 1'b0;
      g_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_vld_r     <= in_valid;
      b_vld_r     <= a_vld_r;
      c_vld_r     <= b_vld_r;
      e_vld_r     <= d0_vld;
      f_vld_r     <= e_vld_r;
      g_vld_r     <= d1_vld;
      out_valid_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r   <= a_side_nxt;
      b_side_r   <= a_side_r;
      b_sqx_r    <= SQ_W'(a_side_r.mag_x) * SQ_W'(a_side_r.mag_x);
      b_sqy_r    <= SQ_W'(a_side_r.mag_y) * SQ_W'(a_side_r.mag_y);
      c_side_r   <= b_side_r;
      c_sq_r     <= b_sqx_r + b_sqy_r;
      e_side_r   <= e_side_nxt;
      e_len_r    <= len;
      e_ae_r     <= ae_nxt;
      f_side_r   <= e_side_r;
      f_len_r    <= e_len_r;
      f_numx_r   <= NUM_W'(e_side_r.mag_x) * NUM_W'(e_ae_r);
      f_numy_r   <= NUM_W'(e_side_r.mag_y) * NUM_W'(e_ae_r);
      g_side_r   <= d1_side;
      g_msum_r   <= DEN_W'(d1_side.m1) + DEN_W'(d1_side.m2);
      g_num_r[0] <= NUM_W'(tx) * NUM_W'(d1_side.m2);
      g_num_r[1] <= NUM_W'(tx) * NUM_W'(d1_side.m1);
      g_num_r[2] <= NUM_W'(ty) * NUM_W'(d1_side.m2);
      g_num_r[3] <= NUM_W'(ty) * NUM_W'(d1_side.m1);
      out_data_r <= out_nxt;
    end
  end

  dcp_sqrt u_sqrt (.clk(clk), .en(adv), .n(c_sq_r), .root(len));

  dcp_delay u_dly0 (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(c_vld_r), .side_in(c_side_r),
    .vld_out(d0_vld), .side_out(d0_side)
  );

  dcp_div u_div_tx (.clk(clk), .en(adv), .num(f_numx_r), .den(f_len_r), .quo(tx));
  dcp_div u_div_ty (.clk(clk), .en(adv), .num(f_numy_r), .den(f_len_r), .quo(ty));

  dcp_delay u_dly1 (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(f_vld_r), .side_in(f_side_r),
    .vld_out(d1_vld), .side_out(d1_side)
  );

  for (genvar k = 0; k < 4; k++) begin : g_mdiv
    dcp_div u_div_m (
      .clk(clk), .en(adv), .num(g_num_r[k]), .den(g_msum_r), .quo(mv[k])
    );
  end

  dcp_delay u_dly2 (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(g_vld_r), .side_in(g_side_r),
    .vld_out(d2_vld), .side_out(d2_side)
  );

  assign tneg_x = d2_side.neg_x ^ d2_side.eneg;
  assign tneg_y = d2_side.neg_y ^ d2_side.eneg;

  always_comb begin
    if (d2_side.degen) begin
      out_nxt.new_first_x  = d2_side.p1x;
      out_nxt.new_first_y  = d2_side.p1y;
      out_nxt.new_second_x = d2_side.p2x;
      out_nxt.new_second_y = d2_side.p2y;
      out_nxt.degenerate   = 1'b1;
    end else begin
      out_nxt.new_first_x  = sat_move(d2_side.p1x, mv[0], tneg_x);
      out_nxt.new_first_y  = sat_move(d2_side.p1y, mv[2], tneg_y);
      out_nxt.new_second_x = sat_move(d2_side.p2x, mv[1], !tneg_x);
      out_nxt.new_second_y = sat_move(d2_side.p2y, mv[3], !tneg_y);
      out_nxt.degenerate   = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
    e_vld_r && !e_side_r.degen |-> e_len_r != '0)
    else $error("non-degenerate transaction with zero length");

  a_msum_nz: assert property (@(posedge clk) disable iff (!rst_n)
    g_vld_r && !g_side_r.degen |-> g_msum_r != '0)
    else $error("non-degenerate transaction with zero mass sum");

  a_rst_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid && !a_vld_r && !g_vld_r)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
